// ===== rtl/txol_pkg.sv =====
// ============================================================================
// txol_pkg
// Shared types and constants for the transaction output locator.
// ============================================================================
package txol_pkg;

    localparam int MAX_TX_BYTES = 65536;
    localparam int POS_W        = $clog2(MAX_TX_BYTES + 1);

    localparam logic [7:0] VL_TWO_PREFIX  = 8'd253;
    localparam logic [7:0] VL_FOUR_PREFIX = 8'd254;
    localparam int         HASH_BYTES     = 256 / 8;
    localparam int         OUTPOINT_BYTES = HASH_BYTES + 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int M_TDATA_W = 104;

    typedef enum logic [1:0] {
        CFG_OUTPUT_INDEX = 2'd0,
        CFG_CHECK_ONLY   = 2'd1,
        CFG_AMOUNT_LIMIT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNCATED  = 3'd1,
        ST_BAD_PREFIX = 3'd2,
        ST_RANGE      = 3'd3,
        ST_TOO_LARGE  = 3'd4,
        ST_TOO_LONG   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_VERSION,
        PH_NIN,
        PH_IN_PREV,
        PH_IN_SSLEN,
        PH_IN_SCRIPT,
        PH_IN_SEQ,
        PH_NOUT,
        PH_OUT_VAL,
        PH_OUT_SKLEN,
        PH_OUT_SCRIPT,
        PH_LOCKTIME
    } phase_t;

    // Meaning of a byte if it opens a variable-length number.
    typedef enum logic [1:0] {
        VL_ONE,
        VL_TWO,
        VL_FOUR,
        VL_BAD
    } vl_class_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        vl_class_t  cls;
    } q_item_t;

    typedef struct packed {
        logic [15:0] output_index;
        logic        check_only;
        logic [63:0] amount_limit;
    } cfg_t;

endpackage

// ===== rtl/txol_front.sv =====
// ============================================================================
// txol_front
// Accepts transaction bytes and classifies each as a length prefix.
// ============================================================================
module txol_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // last_byte
    input  logic              q_full,
    output logic              q_push,
    output txol_pkg::q_item_t q_item
);

    txol_pkg::vl_class_t cls;

    always_comb
    begin
        if (s_tdata < txol_pkg::VL_TWO_PREFIX)
        begin
            cls = txol_pkg::VL_ONE;
        end
        else if (s_tdata == txol_pkg::VL_TWO_PREFIX)
        begin
            cls = txol_pkg::VL_TWO;
        end
        else if (s_tdata == txol_pkg::VL_FOUR_PREFIX)
        begin
            cls = txol_pkg::VL_FOUR;
        end
        else
        begin
            cls = txol_pkg::VL_BAD;
        end
    end

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full;
    assign q_item.data = s_tdata;
    assign q_item.last = s_tlast;
    assign q_item.cls  = cls;

endmodule

// ===== rtl/txol_queue.sv =====
// ============================================================================
// txol_queue
// Short first-in first-out queue between the front and the parser.
// ============================================================================
module txol_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  txol_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output txol_pkg::q_item_t head_item
);

    txol_pkg::q_item_t                 mem_reg [txol_pkg::QUEUE_DEPTH];
    logic [txol_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [txol_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [txol_pkg::QCNT_W-1:0]       count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = (count_reg == txol_pkg::QCNT_W'(txol_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= txol_pkg::QCNT_W'(txol_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/txol_parser.sv =====
// ============================================================================
// txol_parser
// Walks the transaction one byte per cycle, holding while a result waits untaken, and registers the result.
// ============================================================================
module txol_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  txol_pkg::cfg_t                   cfg,
    input  logic                             head_valid,
    input  txol_pkg::q_item_t                head_item,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [txol_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int POS_W = txol_pkg::POS_W;

    logic [POS_W-1:0]       pos_reg, pos_next;
    txol_pkg::phase_t       phase_reg, phase_next;
    logic [3:0]             left_reg, left_next;
    logic [63:0]            acc_reg, acc_next;
    logic [2:0]             idx_reg, idx_next;
    logic [31:0]            inputs_reg, inputs_next;
    logic [31:0]            total_reg, total_next;
    logic [31:0]            counter_reg, counter_next;
    logic [31:0]            skip_reg, skip_next;
    logic [63:0]            captured_reg, captured_next;
    logic [15:0]            start_reg, start_next;
    logic                   finished_reg, finished_next;
    logic                   out_valid_reg, out_valid_next;
    logic [txol_pkg::M_TDATA_W-1:0] out_data_reg;

    logic                   res_valid;
    txol_pkg::status_t      res_status;
    logic                   ext, fdone, skipdone, osd;
    logic [63:0]            v;
    logic [63:0]            acc_new;
    logic [POS_W-1:0]       pos_inc;
    logic                   located;
    logic [15:0]            res_length;

    assign pop     = head_valid && (!out_valid_reg || m_tready);
    assign pos_inc = pos_reg + 1'b1;
    assign acc_new = acc_reg | ({56'd0, head_item.data} << {idx_reg, 3'b000});

    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        left_next     = left_reg;
        acc_next      = acc_reg;
        idx_next      = idx_reg;
        inputs_next   = inputs_reg;
        total_next    = total_reg;
        counter_next  = counter_reg;
        skip_next     = skip_reg;
        captured_next = captured_reg;
        start_next    = start_reg;
        finished_next = finished_reg;
        res_valid     = 1'b0;
        res_status    = txol_pkg::ST_OK;
        ext           = 1'b0;
        fdone         = 1'b0;
        skipdone      = 1'b0;
        osd           = 1'b0;
        v             = '0;

        if (pop && !finished_reg)
        begin
            if (pos_reg >= POS_W'(txol_pkg::MAX_TX_BYTES))
            begin
                res_valid  = 1'b1;
                res_status = txol_pkg::ST_TOO_LONG;
            end
            else
            begin
                pos_next = pos_inc;
                unique case (phase_reg)
                    txol_pkg::PH_NIN, txol_pkg::PH_IN_SSLEN,
                    txol_pkg::PH_NOUT, txol_pkg::PH_OUT_SKLEN:
                    begin
                        if (left_reg == 4'd0)
                        begin
                            unique case (head_item.cls)
                                txol_pkg::VL_ONE:
                                begin
                                    fdone = 1'b1;
                                    v     = {56'd0, head_item.data};
                                end
                                txol_pkg::VL_TWO:
                                begin
                                    left_next = 4'd2;
                                    acc_next  = '0;
                                    idx_next  = '0;
                                end
                                txol_pkg::VL_FOUR:
                                begin
                                    left_next = 4'd4;
                                    acc_next  = '0;
                                    idx_next  = '0;
                                end
                                default:
                                begin
                                    res_valid  = 1'b1;
                                    res_status = txol_pkg::ST_BAD_PREFIX;
                                end
                            endcase
                        end
                        else
                        begin
                            ext = 1'b1;
                        end
                    end
                    txol_pkg::PH_VERSION, txol_pkg::PH_IN_SEQ,
                    txol_pkg::PH_OUT_VAL, txol_pkg::PH_LOCKTIME:
                    begin
                        ext = 1'b1;
                    end
                    default:
                    begin
                        // Skipped bytes: outpoint and scripts.
                        skip_next = skip_reg - 1'b1;
                        skipdone  = (skip_reg == 32'd1);
                    end
                endcase

                if (ext)
                begin
                    acc_next  = acc_new;
                    idx_next  = idx_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == 4'd1)
                    begin
                        fdone = 1'b1;
                        v     = acc_new;
                    end
                end

                if (skipdone)
                begin
                    priority case (phase_reg)
                        txol_pkg::PH_IN_PREV:
                        begin
                            phase_next = txol_pkg::PH_IN_SSLEN;
                            left_next  = 4'd0;
                            acc_next   = '0;
                            idx_next   = '0;
                        end
                        txol_pkg::PH_IN_SCRIPT:
                        begin
                            phase_next = txol_pkg::PH_IN_SEQ;
                            left_next  = 4'd4;
                            acc_next   = '0;
                            idx_next   = '0;
                        end
                        default:
                        begin
                            osd = 1'b1;
                        end
                    endcase
                end

                if (fdone)
                begin
                    unique case (phase_reg)
                        txol_pkg::PH_VERSION:
                        begin
                            phase_next = txol_pkg::PH_NIN;
                            left_next  = 4'd0;
                            acc_next   = '0;
                            idx_next   = '0;
                        end
                        txol_pkg::PH_NIN, txol_pkg::PH_IN_SEQ:
                        begin
                            // Either a fresh input count or the end of one input.
                            if (phase_reg == txol_pkg::PH_NIN)
                            begin
                                inputs_next = v[31] ? 32'd0 : v[31:0];
                            end
                            if (((phase_reg == txol_pkg::PH_NIN) ? inputs_next : inputs_reg)
                                == 32'd0)
                            begin
                                phase_next = txol_pkg::PH_NOUT;
                                left_next  = 4'd0;
                                acc_next   = '0;
                                idx_next   = '0;
                            end
                            else
                            begin
                                inputs_next = ((phase_reg == txol_pkg::PH_NIN)
                                               ? inputs_next : inputs_reg) - 1'b1;
                                phase_next  = txol_pkg::PH_IN_PREV;
                                skip_next   = 32'(txol_pkg::OUTPOINT_BYTES);
                            end
                        end
                        txol_pkg::PH_IN_SSLEN:
                        begin
                            if (v == 64'd0)
                            begin
                                phase_next = txol_pkg::PH_IN_SEQ;
                                left_next  = 4'd4;
                                acc_next   = '0;
                                idx_next   = '0;
                            end
                            else
                            begin
                                phase_next = txol_pkg::PH_IN_SCRIPT;
                                skip_next  = v[31:0];
                            end
                        end
                        txol_pkg::PH_NOUT:
                        begin
                            if (v[31] || (!cfg.check_only &&
                                          {16'd0, cfg.output_index} >= v[31:0]))
                            begin
                                res_valid  = 1'b1;
                                res_status = txol_pkg::ST_RANGE;
                            end
                            else
                            begin
                                total_next   = v[31:0];
                                counter_next = '0;
                                phase_next   = (v == 64'd0) ? txol_pkg::PH_LOCKTIME
                                                            : txol_pkg::PH_OUT_VAL;
                                left_next    = (v == 64'd0) ? 4'd4 : 4'd8;
                                acc_next     = '0;
                                idx_next     = '0;
                            end
                        end
                        txol_pkg::PH_OUT_VAL:
                        begin
                            if (!cfg.check_only && counter_reg == {16'd0, cfg.output_index})
                            begin
                                captured_next = v;
                                start_next    = 16'(pos_inc);
                            end
                            phase_next = txol_pkg::PH_OUT_SKLEN;
                            left_next  = 4'd0;
                            acc_next   = '0;
                            idx_next   = '0;
                        end
                        txol_pkg::PH_OUT_SKLEN:
                        begin
                            if (v == 64'd0)
                            begin
                                osd = 1'b1;
                            end
                            else
                            begin
                                phase_next = txol_pkg::PH_OUT_SCRIPT;
                                skip_next  = v[31:0];
                            end
                        end
                        txol_pkg::PH_LOCKTIME:
                        begin
                            res_valid  = 1'b1;
                            res_status = txol_pkg::ST_OK;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // End of one output's script.
                if (osd)
                begin
                    if (!cfg.check_only && counter_reg == {16'd0, cfg.output_index})
                    begin
                        res_valid  = 1'b1;
                        res_status = (captured_reg > cfg.amount_limit)
                                     ? txol_pkg::ST_TOO_LARGE : txol_pkg::ST_OK;
                    end
                    else
                    begin
                        counter_next = counter_reg + 1'b1;
                        acc_next     = '0;
                        idx_next     = '0;
                        if (counter_next == total_reg)
                        begin
                            if (!cfg.check_only)
                            begin
                                res_valid  = 1'b1;
                                res_status = txol_pkg::ST_RANGE;
                            end
                            else
                            begin
                                phase_next = txol_pkg::PH_LOCKTIME;
                                left_next  = 4'd4;
                            end
                        end
                        else
                        begin
                            phase_next = txol_pkg::PH_OUT_VAL;
                            left_next  = 4'd8;
                        end
                    end
                end

                if (!res_valid && head_item.last)
                begin
                    res_valid  = 1'b1;
                    res_status = txol_pkg::ST_TRUNCATED;
                end
            end
        end

        if (res_valid)
        begin
            finished_next = 1'b1;
        end

        // The last byte rearms the parser for the next transaction.
        if (pop && head_item.last)
        begin
            pos_next      = '0;
            phase_next    = txol_pkg::PH_VERSION;
            left_next     = 4'd4;
            acc_next      = '0;
            idx_next      = '0;
            inputs_next   = '0;
            total_next    = '0;
            counter_next  = '0;
            skip_next     = '0;
            captured_next = '0;
            start_next    = '0;
            finished_next = 1'b0;
        end
    end

    assign located    = (res_status == txol_pkg::ST_OK) && !cfg.check_only;
    assign res_length = 16'(pos_inc) - start_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            out_data_reg <= {5'd0,
                             located ? res_length : 16'd0,
                             located ? start_reg : 16'd0,
                             located ? captured_reg : 64'd0,
                             res_status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= txol_pkg::PH_VERSION;
            left_reg      <= 4'd4;
            acc_reg       <= '0;
            idx_reg       <= '0;
            inputs_reg    <= '0;
            total_reg     <= '0;
            counter_reg   <= '0;
            skip_reg      <= '0;
            captured_reg  <= '0;
            start_reg     <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            inputs_reg    <= inputs_next;
            total_reg     <= total_next;
            counter_reg   <= counter_next;
            skip_reg      <= skip_next;
            captured_reg  <= captured_next;
            start_reg     <= start_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result at the end of an output script leaves the phase in place with
    // nothing left to skip, so only an unfinished parse is checked.
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!finished_reg &&
         (phase_reg == txol_pkg::PH_IN_PREV || phase_reg == txol_pkg::PH_IN_SCRIPT ||
          phase_reg == txol_pkg::PH_OUT_SCRIPT)) |-> skip_reg != 32'd0)
        else $error("skip phase entered with nothing to skip");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(txol_pkg::MAX_TX_BYTES))
        else $error("byte position beyond transaction limit");

    a_finish_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_valid && !head_item.last) |=> finished_reg)
        else $error("result given but parser not finished");

    a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !res_valid)
        else $error("second result within one transaction");

endmodule

// ===== rtl/tx_output_locator.sv =====
// ============================================================================
// tx_output_locator
// Streaming locator of one output of a serialized transaction.
// ============================================================================
// The transaction arrives one byte per transfer on the s_ channel, with
// s_tlast on its final byte. The parser walks version, inputs and outputs
// and returns one result per transaction on the m_ channel: a status, and
// for a located output its amount, the offset of its script length prefix
// and the script length including that prefix.
// The cfg_ channel writes output_index (0), check_only (1) and the amount
// limit (2); it is always ready and must only be used while no transaction
// is in flight.
// An accepted byte enters a four-entry queue; the parser takes it from the
// queue head and loads any result it decides into the output register at
// that same edge; the output register drives m_tvalid. The parser retires
// one byte per cycle unless a result waits untaken, so the sustained rate is
// one byte per clock while the receiver keeps up.
// When the receiver stalls with a result waiting, the parser holds; the
// queue absorbs up to four more bytes and then s_tready drops until the
// result is taken.
// Reset clears the parser to the start of a transaction and restores the
// default register values (amount limit 2100000000000000).
// ============================================================================
module tx_output_locator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    input  logic         s_tlast,     // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [66:3] amount, [82:67] script_offset,
    // [98:83] script_length, [103:99] zero
    output logic [103:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    txol_pkg::cfg_t    cfg_reg, cfg_next;
    txol_pkg::q_item_t push_item;
    txol_pkg::q_item_t head_item;
    logic              push;
    logic              q_full;
    logic              head_valid;
    logic              pop;

    // Configuration registers; writes to an unused index are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                txol_pkg::CFG_OUTPUT_INDEX: cfg_next.output_index = cfg_data[15:0];
                txol_pkg::CFG_CHECK_ONLY:   cfg_next.check_only   = cfg_data[0];
                txol_pkg::CFG_AMOUNT_LIMIT: cfg_next.amount_limit = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_index <= '0;
            cfg_reg.check_only   <= 1'b0;
            cfg_reg.amount_limit <= 64'd2100000000000000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    txol_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (push),
        .q_item   (push_item)
    );

    txol_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    txol_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== sim/tx_output_locator_tb.sv =====
// ============================================================================
// tx_output_locator_tb
// Self-checking testbench for the transaction output locator.
// ============================================================================
// Bytes of serialized transactions are pushed into the s_ channel, one per
// handshake, and a cycle-free predictor of the parser works out the result
// each accepted byte causes. Results taken from the m_ channel are compared
// field by field with the oldest prediction. A short directed table covers
// the truncated, bad-prefix, range and too-large codes and field extremes.
// Random well-formed transactions with random content, broken transactions
// and noise then run under several register settings.
// ============================================================================
module tx_output_locator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_STATUS = -1;

    // ------------------------------------------------------------------------
    // Block ports.
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'd0;      // [7:0] data_byte
    logic                 s_tlast = 1'b0;      // last_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [2:0] status, [66:3] amount, [82:67] script_offset,
    // [98:83] script_length, [103:99] zero
    logic [103:0]         m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    txol_pkg::cfg_index_t cfg_index = txol_pkg::CFG_OUTPUT_INDEX;
    logic [63:0]          cfg_data = 64'd0;

    tx_output_locator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Types and bookkeeping.
    // ------------------------------------------------------------------------
    typedef struct packed {
        txol_pkg::status_t status;
        logic [63:0]       amount;
        logic [15:0]       offset;
        logic [15:0]       length;
    } locate_result_t;

    // One row of the directed table. Rows marked typed carry a hand-written
    // status; their other result fields are all zero since every typed row is
    // an error case.
    typedef struct {
        logic [7:0]        data;
        bit                last;
        bit                typed;
        txol_pkg::status_t status;
    } stim_row_t;

    locate_result_t pending[$];      // predicted results not yet seen
    logic [7:0]     frame_bytes[$];  // transaction under construction
    int unsigned    mismatch_count = 0;
    int unsigned    random_bytes = 0;
    bit             sender_idle_on = 1'b1;
    bit             receiver_idle_on = 1'b1;
    int unsigned    hold_cnt = 0;

    // ------------------------------------------------------------------------
    // Predictor: register copies and parser state.
    // ------------------------------------------------------------------------
    logic [15:0] m_index;
    bit          m_check;
    logic [63:0] m_max;

    int unsigned      pos;
    txol_pkg::phase_t phase;
    int unsigned      fld_left;
    logic [63:0]      fld_acc;
    int unsigned      fld_shift;
    int unsigned      ins_left;
    int unsigned      outs_total;
    int unsigned      out_cnt;
    int unsigned      skip_left;
    logic [63:0]      cap_amount;
    int unsigned      scr_start;
    bit               done_flag;

    function automatic void begin_field(txol_pkg::phase_t ph, int unsigned n);
        phase     = ph;
        fld_left  = n;
        fld_acc   = 64'd0;
        fld_shift = 0;
    endfunction

    function automatic void rearm_parser();
        pos = 0;
        begin_field(txol_pkg::PH_VERSION, 4);
        ins_left   = 0;
        outs_total = 0;
        out_cnt    = 0;
        skip_left  = 0;
        cap_amount = 64'd0;
        scr_start  = 0;
        done_flag  = 1'b0;
    endfunction

    function automatic void advance_input();
        if (ins_left == 0)
        begin
            begin_field(txol_pkg::PH_NOUT, 0);
        end
        else
        begin
            ins_left--;
            phase     = txol_pkg::PH_IN_PREV;
            skip_left = txol_pkg::OUTPOINT_BYTES;
        end
    endfunction

    // Called once the script of an output has been passed.
    function automatic int output_script_end();
        if (!m_check && out_cnt == {16'd0, m_index})
            return (cap_amount > m_max) ? txol_pkg::ST_TOO_LARGE : txol_pkg::ST_OK;
        out_cnt++;
        if (out_cnt == outs_total)
        begin
            if (!m_check)
                return txol_pkg::ST_RANGE;
            begin_field(txol_pkg::PH_LOCKTIME, 4);
        end
        else
        begin
            begin_field(txol_pkg::PH_OUT_VAL, 8);
        end
        return NO_STATUS;
    endfunction

    function automatic int field_complete(logic [63:0] v);
        logic negative;
        negative = v[31];
        unique case (phase)
            txol_pkg::PH_VERSION:
            begin
                begin_field(txol_pkg::PH_NIN, 0);
            end
            txol_pkg::PH_NIN:
            begin
                // Counts with the top bit set count as negative: no inputs.
                ins_left = negative ? 0 : v[31:0];
                advance_input();
            end
            txol_pkg::PH_IN_SSLEN:
            begin
                if (v == 64'd0)
                begin
                    begin_field(txol_pkg::PH_IN_SEQ, 4);
                end
                else
                begin
                    phase     = txol_pkg::PH_IN_SCRIPT;
                    skip_left = v[31:0];
                end
            end
            txol_pkg::PH_IN_SEQ:
            begin
                advance_input();
            end
            txol_pkg::PH_NOUT:
            begin
                if (negative || (!m_check && {48'd0, m_index} >= v))
                    return txol_pkg::ST_RANGE;
                outs_total = v[31:0];
                out_cnt    = 0;
                if (v == 64'd0)
                    begin_field(txol_pkg::PH_LOCKTIME, 4);
                else
                    begin_field(txol_pkg::PH_OUT_VAL, 8);
            end
            txol_pkg::PH_OUT_VAL:
            begin
                if (!m_check && out_cnt == {16'd0, m_index})
                begin
                    cap_amount = v;
                    scr_start  = pos;
                end
                begin_field(txol_pkg::PH_OUT_SKLEN, 0);
            end
            txol_pkg::PH_OUT_SKLEN:
            begin
                if (v == 64'd0)
                    return output_script_end();
                phase     = txol_pkg::PH_OUT_SCRIPT;
                skip_left = v[31:0];
            end
            txol_pkg::PH_LOCKTIME:
            begin
                return txol_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
        return NO_STATUS;
    endfunction

    // Adds one little-endian byte to the field being gathered.
    function automatic int accumulate(logic [7:0] b);
        fld_acc   = fld_acc | ({56'd0, b} << (fld_shift & 63));
        fld_shift = fld_shift + 8;
        fld_left--;
        return (fld_left == 0) ? field_complete(fld_acc) : NO_STATUS;
    endfunction

    function automatic int absorb_byte(logic [7:0] b);
        unique case (phase)
            txol_pkg::PH_NIN, txol_pkg::PH_IN_SSLEN,
            txol_pkg::PH_NOUT, txol_pkg::PH_OUT_SKLEN:
            begin
                // A variable-length number opens with its size byte.
                if (fld_left == 0)
                begin
                    if (b < txol_pkg::VL_TWO_PREFIX)
                        return field_complete({56'd0, b});
                    if (b == txol_pkg::VL_TWO_PREFIX)
                        fld_left = 2;
                    else if (b == txol_pkg::VL_FOUR_PREFIX)
                        fld_left = 4;
                    else
                        return txol_pkg::ST_BAD_PREFIX;
                    fld_acc   = 64'd0;
                    fld_shift = 0;
                    return NO_STATUS;
                end
                return accumulate(b);
            end
            txol_pkg::PH_VERSION, txol_pkg::PH_IN_SEQ,
            txol_pkg::PH_OUT_VAL, txol_pkg::PH_LOCKTIME:
            begin
                return accumulate(b);
            end
            txol_pkg::PH_IN_PREV, txol_pkg::PH_IN_SCRIPT, txol_pkg::PH_OUT_SCRIPT:
            begin
                skip_left--;
                if (skip_left != 0)
                    return NO_STATUS;
                if (phase == txol_pkg::PH_IN_PREV)
                    begin_field(txol_pkg::PH_IN_SSLEN, 0);
                else if (phase == txol_pkg::PH_IN_SCRIPT)
                    begin_field(txol_pkg::PH_IN_SEQ, 4);
                else
                    return output_script_end();
                return NO_STATUS;
            end
            default:
            begin
                return NO_STATUS;
            end
        endcase
    endfunction

    // Steps the predictor by one accepted byte; returns 1 when it causes a
    // result, which is then placed in res.
    function automatic bit predict_byte(input logic [7:0] b, input bit last,
                                        output locate_result_t res);
        int          code;
        bit          located;
        int unsigned span;
        code = NO_STATUS;
        res  = '0;
        if (!done_flag)
        begin
            if (pos >= txol_pkg::MAX_TX_BYTES)
            begin
                code = txol_pkg::ST_TOO_LONG;
            end
            else
            begin
                pos++;
                code = absorb_byte(b);
                if (code == NO_STATUS && last)
                    code = txol_pkg::ST_TRUNCATED;
            end
        end
        if (code != NO_STATUS)
        begin
            located    = (code == txol_pkg::ST_OK) && !m_check;
            span       = pos - scr_start;
            res.status = txol_pkg::status_t'(code);
            res.amount = located ? cap_amount : 64'd0;
            res.offset = located ? scr_start[15:0] : 16'd0;
            res.length = located ? span[15:0] : 16'd0;
            done_flag  = 1'b1;
        end
        if (last)
            rearm_parser();
        return code != NO_STATUS;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The slowest correct run stays far below this: some two thousand bytes
    // with random gaps, random stalls on every result and the drains add up
    // to well under a millisecond.
    initial
    begin
        #16_000_000;
        $display("tx_output_locator_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field compare.
    // Outputs are sampled at the edge, before this edge's updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        locate_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending.size() == 0)
                begin
                    $display("%0t: result expected none, actual tdata %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending.pop_front();
                    if (m_tdata[2:0] != want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[66:3] != want.amount)
                    begin
                        $display("%0t: amount expected %h, actual %h",
                                 $time, want.amount, m_tdata[66:3]);
                        mismatch_count++;
                    end
                    if (m_tdata[82:67] != want.offset)
                    begin
                        $display("%0t: script_offset expected %0d, actual %0d",
                                 $time, want.offset, m_tdata[82:67]);
                        mismatch_count++;
                    end
                    if (m_tdata[98:83] != want.length)
                    begin
                        $display("%0t: script_length expected %0d, actual %0d",
                                 $time, want.length, m_tdata[98:83]);
                        mismatch_count++;
                    end
                end
                hold_cnt = receiver_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (hold_cnt != 0)
            begin
                m_tready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one byte after a random gap and waits for the handshake. The
    // predictor is stepped on acceptance.
    task automatic send_byte(input logic [7:0] b, input bit last,
                             output bit hit, output locate_result_t res);
        int unsigned gap;
        gap = sender_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        hit = predict_byte(b, last, res);
    endtask

    // Sends the transaction in frame_bytes, flagging its final byte.
    task automatic send_frame(input bit count_it);
        bit             hit;
        locate_result_t res;
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            // Now and then hold the stream until every result is out.
            if (count_it && $urandom_range(0, 199) == 0)
                drain_results(1);
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, hit, res);
            if (hit)
                pending.push_back(res);
            if (count_it)
                random_bytes++;
        end
    endtask

    // Stops the sender until all predicted results have arrived, then lets
    // tail more cycles pass so that queued bytes with no result retire too.
    task automatic drain_results(input int unsigned tail);
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Writes all three registers back to back on the configuration channel.
    task automatic program_registers(input logic [15:0] idx, input bit chk,
                                     input logic [63:0] maxv);
        txol_pkg::cfg_index_t regs[3];
        logic [63:0]          vals[3];
        regs = '{txol_pkg::CFG_OUTPUT_INDEX, txol_pkg::CFG_CHECK_ONLY,
                 txol_pkg::CFG_AMOUNT_LIMIT};
        vals = '{{48'd0, idx}, {63'd0, chk}, maxv};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            unique case (regs[i])
                txol_pkg::CFG_OUTPUT_INDEX: m_index = idx;
                txol_pkg::CFG_CHECK_ONLY:   m_check = chk;
                default:                    m_max   = maxv;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_random(input int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    // Encodes a count in any of the legal widths, not only the shortest.
    function automatic void put_varint(input logic [31:0] v);
        if (v < 253 && $urandom_range(0, 3) != 0)
        begin
            frame_bytes.push_back(v[7:0]);
        end
        else if (v < 65536 && $urandom_range(0, 1) == 1)
        begin
            frame_bytes.push_back(txol_pkg::VL_TWO_PREFIX);
            put_le({32'd0, v}, 2);
        end
        else
        begin
            frame_bytes.push_back(txol_pkg::VL_FOUR_PREFIX);
            put_le({32'd0, v}, 4);
        end
    endfunction

    // Builds a transaction: mostly well formed with random content, some cut
    // short or with a damaged byte, and some plain noise.
    function automatic void build_frame();
        int unsigned n_in, n_out, len, pick;
        logic [63:0] amount;
        frame_bytes.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            put_random($urandom_range(1, 12));
            return;
        end
        put_le({32'd0, 32'($urandom)}, 4);
        // Input count, occasionally one that acts as negative.
        if ($urandom_range(0, 15) == 0)
        begin
            frame_bytes.push_back(txol_pkg::VL_FOUR_PREFIX);
            put_le({32'd0, 1'b1, 31'($urandom)}, 4);
            n_in = 0;
        end
        else
        begin
            n_in = $urandom_range(0, 2);
            put_varint(n_in);
        end
        repeat (n_in)
        begin
            put_random(txol_pkg::OUTPOINT_BYTES);
            len = $urandom_range(0, 5);
            put_varint(len);
            put_random(len);
            put_le({32'd0, 32'($urandom)}, 4);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            frame_bytes.push_back(txol_pkg::VL_FOUR_PREFIX);
            put_le({32'd0, 1'b1, 31'($urandom)}, 4);
            n_out = 0;
        end
        else
        begin
            n_out = $urandom_range(0, 4);
            put_varint(n_out);
        end
        repeat (n_out)
        begin
            // Amounts are small, fully random, or right at the limit.
            pick = $urandom_range(0, 3);
            unique case (pick)
                0:       amount = 64'($urandom_range(0, 1000));
                1:       amount = {32'($urandom), 32'($urandom)};
                2:       amount = m_max + 64'($urandom_range(0, 2)) - 64'd1;
                default: amount = 64'd0;
            endcase
            put_le(amount, 8);
            len = $urandom_range(0, 5);
            put_varint(len);
            put_random(len);
        end
        put_le({32'd0, 32'($urandom)}, 4);
        put_random($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            len = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
        end
        else if (pick < 16)
        begin
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
                ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t      directed_rows [27];
        bit             hit;
        locate_result_t res;
        locate_result_t typed_res;
        int unsigned    tx_no;
        int unsigned    pick;
        logic [15:0]    idx;
        bit             chk;
        logic [63:0]    maxv;

        // Predictor starts from the reset state of the block.
        m_index = 16'd0;
        m_check = 1'b0;
        m_max   = 64'd2100000000000000;
        rearm_parser();

        // Directed table, run with the reset register values. The typed rows
        // close an error case; the rest are checked against the predictor.
        directed_rows = '{
            // A lone byte flagged last ends the parse early.
            '{8'h00, 1'b1, 1'b1, txol_pkg::ST_TRUNCATED},
            // All-ones version, then a size byte of 0xFF.
            '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'hFF, 1'b1, 1'b1, txol_pkg::ST_BAD_PREFIX},
            // No inputs and no outputs: output 0 cannot be located.
            '{8'h80, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'h7F, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'h01, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFE, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'h00, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'h00, 1'b1, 1'b1, txol_pkg::ST_RANGE},
            // One output of the largest amount with an empty script.
            '{8'h01, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'h00, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'h00, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'h01, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, txol_pkg::ST_OK},
            '{8'h00, 1'b1, 1'b1, txol_pkg::ST_TOO_LARGE}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].last, hit, res);
            if (directed_rows[i].typed)
            begin
                typed_res        = '0;
                typed_res.status = directed_rows[i].status;
                pending.push_back(typed_res);
            end
            else if (hit)
            begin
                pending.push_back(res);
            end
        end

        // Random part. Every fourth transaction the stream is drained and the
        // registers rewritten; the first two settings are the extremes.
        tx_no = 0;
        while (random_bytes < 2000)
        begin
            if (tx_no % 4 == 0)
            begin
                drain_results(16);
                if (tx_no == 0)
                begin
                    idx  = 16'hFFFF;
                    chk  = 1'b0;
                    maxv = 64'd0;
                end
                else if (tx_no == 4)
                begin
                    idx  = 16'd0;
                    chk  = 1'b1;
                    maxv = '1;
                end
                else
                begin
                    idx  = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                      : 16'($urandom_range(0, 3));
                    chk  = ($urandom_range(0, 2) == 0);
                    pick = $urandom_range(0, 4);
                    unique case (pick)
                        0:       maxv = 64'd0;
                        1:       maxv = '1;
                        2:       maxv = 64'd2100000000000000;
                        3:       maxv = {32'($urandom), 32'($urandom)};
                        default: maxv = 64'($urandom_range(0, 1000));
                    endcase
                end
                program_registers(idx, chk, maxv);
                // Some phases run with no idling on one side or both.
                sender_idle_on   = ($urandom_range(0, 2) != 0);
                receiver_idle_on = ($urandom_range(0, 2) != 0);
            end
            build_frame();
            send_frame(1'b1);
            tx_no++;
        end

        // Let every result come out, then watch a while for strays.
        drain_results(32);
        if (mismatch_count == 0 && pending.size() == 0)
            $display("tx_output_locator_tb: done, clean");
        else
            $display("tx_output_locator_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/txol_pkg.sv
rtl/txol_front.sv
rtl/txol_queue.sv
rtl/txol_parser.sv
rtl/tx_output_locator.sv
sim/tx_output_locator_tb.sv
